@@ rtl/core/csa_pkg.sv @@
// Shared constants, register codes and controller/datapath link types for the averager.
package csa_pkg;

  localparam int CSA_WINDOW_DEPTH   = 8;
  localparam int CSA_MEAN_FRAC_BITS = 16;

  // Shunt LSB is 10 uV, 100 A per 75 mV -> 40/3 mA per LSB
  localparam int MA_NUM = 40;
  localparam int MA_DEN = 3;

  localparam logic [15:0] FAULT_LIMIT_RST = 16'd20;
  localparam logic [15:0] RUN_MAX         = 16'hFFFF;
  localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 256;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGN_NEG    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIMIT = 2'd2;

  typedef struct packed {
    logic capture;
    logic upd;
    logic divm_start;
    logic mean;
    logic mul_start;
    logic mul_run;
    logic inc;
    logic acc;
    logic cur_start;
    logic cur;
    logic load_out;
  } csa_cmd_t;

  typedef struct packed {
    logic sample;
    logic div_done;
    logic mul_done;
  } csa_sts_t;

endpackage

@@ rtl/core/csa_div.sv @@
// Restoring divider, one quotient bit per cycle, left-aligned dividend.
module csa_div import csa_pkg::*; #(
  parameter int QW = 42
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [QW-1:0]           dvd_in,
  input  logic [31:0]             dvs_in,
  input  logic [$clog2(QW+1)-1:0] len,
  output logic [QW-1:0]           quot,
  output logic                    done
);

  localparam int LW = $clog2(QW+1);

  logic [QW-1:0] dvd;
  logic [31:0]   dvs;
  logic [31:0]   rem;
  logic [LW-1:0] cnt;
  logic          busy;
  logic [32:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem, dvd[QW-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= len;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == LW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dvd_in;
      dvs  <= dvs_in;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      dvd  <= dvd << 1;
      rem  <= ge ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
      quot <= {quot[QW-2:0], ge};
    end
  end

endmodule

@@ rtl/core/csa_dp.sv @@
// Datapath: config, fault counters, ring sum, Welford accumulator, current conversion.
module csa_dp import csa_pkg::*; #(
  parameter int WINDOW_DEPTH   = CSA_WINDOW_DEPTH,
  parameter int MEAN_FRAC_BITS = CSA_MEAN_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_action,
  input  logic                  in_ack,
  input  logic [15:0]           in_sample,
  input  csa_cmd_t              cmd,
  output csa_sts_t              sts,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int W   = WINDOW_DEPTH;
  localparam int F   = MEAN_FRAC_BITS;
  localparam int PIW = $clog2(W);
  localparam int TW  = 16 + $clog2(W);
  localparam int SW  = (TW > 19) ? TW : 19;
  localparam int DFW = TW + 2;
  localparam int NW  = DFW + 6;
  localparam int CW  = NW + 1;
  localparam int XW  = 16 + F;
  localparam int MW  = ((XW > 32) ? XW : 32) + 1;
  localparam int QW  = MW + 1;
  localparam int DW  = MW + 1;
  localparam int MFW = QW + 2;
  localparam int HW  = (MW + 1) / 2;
  localparam int PW  = 4 * HW;
  localparam int LW  = $clog2(QW + 1);
  localparam int CUR_DEN  = MA_DEN * W;
  localparam int CUR_HALF = (MA_DEN * W) / 2;
  // reciprocal of the current divisor: exact floor for any dividend below 2^CW
  localparam int RS  = CW + $clog2(CUR_DEN);
  localparam int QB  = 2 * CW + 2 - RS;

  localparam logic signed [DFW-1:0] WK   = DFW'(W);
  localparam logic signed [NW-1:0]  K40  = NW'(MA_NUM);
  localparam logic signed [MFW-1:0] MMAX = MFW'(64'sd2147483647);
  localparam logic signed [MFW-1:0] MMIN = MFW'(-64'sd2147483648);
  localparam logic [PW:0]           RND  = (PW+1)'(1) << (2*F - 1);
  localparam logic [PW:0]           M2LIM = (PW+1)'({63{1'b1}});
  localparam logic [CW+1:0]         RM   =
    (CW+2)'(((64'd1 << RS) + 64'(CUR_DEN) - 64'd1) / 64'(CUR_DEN));

  // config
  logic signed [15:0] zero_offset;
  logic               sign_neg;
  logic [15:0]        fault_limit;

  // captured beat
  logic               act_q;
  logic               ack_q;
  logic signed [15:0] x_q;

  // model state
  logic [15:0]        fail_run;
  logic [31:0]        fail_count;
  logic               lost;
  logic signed [15:0] held;
  logic signed [15:0] ring [W];
  logic [W-1:0]       vld;
  logic signed [15:0] rd_q;
  logic signed [TW-1:0] total;
  logic [PIW-1:0]     pos;
  logic               primed;
  logic [31:0]        count;
  logic signed [31:0] mean;
  logic [62:0]        m2;
  logic signed [15:0] lo_mark;
  logic signed [15:0] hi_mark;

  // Welford working regs
  logic               d_neg;
  logic [MW-1:0]      d_mag;
  logic               e_neg;
  logic [MW-1:0]      e_mag;
  logic [2:0]         step;
  logic [2*HW-1:0]    pp_q;
  logic [1:0]         sh_q;
  logic [PW-1:0]      acc;
  logic [62:0]        inc;
  logic signed [31:0] m_sat;
  logic [63:0]        m2_sum;
  logic               cur_neg;
  logic signed [19:0] cur_ma;

  // divider link
  logic [QW-1:0]      div_quot;
  logic               div_done;
  logic [QW-1:0]      div_dvd;
  logic [31:0]        div_dvs;
  logic [LW-1:0]      div_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset <= '0;
      sign_neg    <= 1'b0;
      fault_limit <= FAULT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ZERO_OFFSET: zero_offset <= cfg_wdata;
        CFG_SIGN_NEG:    sign_neg    <= cfg_wdata[0];
        CFG_FAULT_LIMIT: fault_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= in_action;
      ack_q <= in_ack;
      x_q   <= in_sample;
    end
  end

  assign sts.sample   = !act_q && ack_q;
  assign sts.div_done = div_done;
  assign sts.mul_done = (step == 3'd4);

  // next-state helpers
  logic [15:0]          run_inc;
  logic [31:0]          cnt_inc;
  logic signed [XW-1:0] xf;
  logic signed [DW-1:0] d_c;

  assign run_inc = (fail_run == RUN_MAX) ? fail_run : fail_run + 16'd1;
  assign cnt_inc = (count == COUNT_MAX) ? count : count + 32'd1;
  assign xf      = {x_q, {F{1'b0}}};
  assign d_c     = DW'(xf) - DW'(mean);

  // ring memory, registered read of the current slot
  always_ff @(posedge clk) begin
    if (cmd.upd && sts.sample) ring[pos] <= x_q;
    rd_q <= vld[pos] ? ring[pos] : 16'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_run   <= '0;
      fail_count <= '0;
      lost       <= 1'b0;
      held       <= '0;
      vld        <= '0;
      total      <= '0;
      pos        <= '0;
      primed     <= 1'b0;
      count      <= '0;
      mean       <= '0;
      m2         <= '0;
      lo_mark    <= '0;
      hi_mark    <= '0;
    end else begin
      if (cmd.upd) begin
        if (act_q) begin
          count   <= '0;
          mean    <= '0;
          m2      <= '0;
          lo_mark <= '0;
          hi_mark <= '0;
        end else if (!ack_q) begin
          fail_count <= fail_count + 32'd1;
          fail_run   <= run_inc;
          if (run_inc >= fault_limit) lost <= 1'b1;
        end else begin
          fail_run <= '0;
          lost     <= 1'b0;
          held     <= x_q;
          vld[pos] <= 1'b1;
          total    <= total - TW'(rd_q) + TW'(x_q);
          pos      <= (pos == PIW'(W - 1)) ? '0 : pos + 1'b1;
          if (pos == PIW'(W - 1)) primed <= 1'b1;
          if (count == '0) begin
            lo_mark <= x_q;
            hi_mark <= x_q;
          end else begin
            if (x_q < lo_mark) lo_mark <= x_q;
            if (x_q > hi_mark) hi_mark <= x_q;
          end
          count <= cnt_inc;
        end
      end
      if (cmd.mean) mean <= m_sat;
      if (cmd.acc) begin
        if (d_neg == e_neg) m2 <= m2_sum[63] ? {63{1'b1}} : m2_sum[62:0];
        else                m2 <= (inc > m2) ? '0 : m2 - inc;
      end
    end
  end

  // d = X - mean, captured with the old mean
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      d_neg <= d_c[DW-1];
      d_mag <= MW'(d_c[DW-1] ? -d_c : d_c);
    end
  end

  // current conversion dividend from the ring sum
  logic signed [DFW-1:0] cdiff;
  logic signed [NW-1:0]  cnum;
  logic [NW-1:0]         cmag;
  logic [CW-1:0]         cdvd;

  assign cdiff = DFW'(total) - DFW'(zero_offset) * WK;
  assign cnum  = NW'(cdiff) * K40;
  assign cmag  = cnum[NW-1] ? NW'(-cnum) : NW'(cnum);
  assign cdvd  = CW'(cmag) + CW'(CUR_HALF);

  // divider serves the mean update only: (|d| + n/2) / n
  assign div_dvd = QW'(d_mag) + QW'(count >> 1);
  assign div_dvs = count;
  assign div_len = LW'(QW);

  csa_div #(.QW(QW)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.divm_start),
    .dvd_in (div_dvd),
    .dvs_in (div_dvs),
    .len    (div_len),
    .quot   (div_quot),
    .done   (div_done)
  );

  // new mean and e = X - new mean
  logic signed [MFW-1:0] qx;
  logic signed [MFW-1:0] m_full;
  logic signed [DW-1:0]  e_c;

  assign qx     = MFW'(div_quot);
  assign m_full = MFW'(mean) + (d_neg ? -qx : qx);

  always_comb begin
    priority if (m_full > MMAX) m_sat = 32'sh7FFF_FFFF;
    else if (m_full < MMIN)     m_sat = 32'sh8000_0000;
    else                        m_sat = m_full[31:0];
  end

  assign e_c = DW'(xf) - DW'(m_sat);

  always_ff @(posedge clk) begin
    if (cmd.mean) begin
      e_neg <= e_c[DW-1];
      e_mag <= MW'(e_c[DW-1] ? -e_c : e_c);
    end
  end

  // |d|*|e| from four half-width partial products
  logic [2*HW-1:0] a_w, b_w;
  logic [HW-1:0]   a_h, b_h;
  logic [PW-1:0]   pp_sh;

  assign a_w = (2*HW)'(d_mag);
  assign b_w = (2*HW)'(e_mag);
  assign a_h = step[0] ? a_w[2*HW-1:HW] : a_w[HW-1:0];
  assign b_h = step[1] ? b_w[2*HW-1:HW] : b_w[HW-1:0];

  always_comb begin
    unique case (sh_q)
      2'd0:    pp_sh = PW'(pp_q);
      2'd1:    pp_sh = PW'(pp_q) << HW;
      default: pp_sh = PW'(pp_q) << (2*HW);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.mul_start) begin
      step <= '0;
    end else if (cmd.mul_run && step != 3'd4) begin
      step <= step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      acc <= '0;
    end else if (cmd.mul_run) begin
      if (step != 3'd4) begin
        pp_q <= a_h * b_h;
        sh_q <= 2'(step[0]) + 2'(step[1]);
      end
      if (step != 3'd0) acc <= acc + pp_sh;
    end
  end

  // rounded, scaled increment, then saturating accumulate
  logic [PW:0] rnd_sum;
  logic [PW:0] inc_w;

  assign rnd_sum = (PW+1)'(acc) + RND;
  assign inc_w   = rnd_sum >> (2*F);
  assign m2_sum  = {1'b0, m2} + {1'b0, inc};

  // current divide by 3*depth: register the dividend, then one reciprocal multiply
  logic [CW-1:0]   cdvd_q;
  logic [2*CW+1:0] cprod;
  logic [QB-1:0]   cquo;

  assign cprod = cdvd_q * RM;

  always_ff @(posedge clk) begin
    if (cmd.inc) inc <= (inc_w > M2LIM) ? {63{1'b1}} : inc_w[62:0];
    if (cmd.cur_start) begin
      cur_neg <= cnum[NW-1];
      cdvd_q  <= cdvd;
    end
    cquo <= cprod[2*CW+1:RS];
  end

  // current from the quotient
  logic neg_final;
  assign neg_final = cur_neg ^ sign_neg;

  always_ff @(posedge clk) begin
    if (cmd.cur) begin
      priority if (!neg_final && cquo > QB'(524287)) cur_ma <= 20'sd524287;
      else if (neg_final && cquo > QB'(524288))      cur_ma <= -20'sd524288;
      else if (neg_final)                            cur_ma <= -cquo[19:0];
      else                                           cur_ma <= cquo[19:0];
    end
  end

  logic signed [SW-1:0] tx;
  assign tx = SW'(total);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {7'd0, hi_mark, lo_mark, m2, mean, count, primed, cur_ma, tx[18:0],
                   held, fail_count, (fail_run != 16'd0), lost};
    end
  end

endmodule

@@ rtl/core/csa_ctrl.sv @@
// Controller: sequences a beat via update, mean divide/multiply/M2 if acked, current.
module csa_ctrl import csa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_valid,
  output logic     s_ready,
  output logic     m_valid,
  input  logic     m_ready,
  input  csa_sts_t sts,
  output csa_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UPD    = 4'd1;
  localparam logic [3:0] S_MSTART = 4'd2;
  localparam logic [3:0] S_DIVM   = 4'd3;
  localparam logic [3:0] S_MEAN   = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_INC    = 4'd6;
  localparam logic [3:0] S_ACC    = 4'd7;
  localparam logic [3:0] S_CSTART = 4'd8;
  localparam logic [3:0] S_CMUL   = 4'd9;
  localparam logic [3:0] S_CUR    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0] state, state_next;

  assign s_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = sts.sample ? S_MSTART : S_CSTART;
      end
      S_MSTART: begin
        cmd.divm_start = 1'b1;
        state_next     = S_DIVM;
      end
      S_DIVM: begin
        if (sts.div_done) state_next = S_MEAN;
      end
      S_MEAN: begin
        cmd.mean      = 1'b1;
        cmd.mul_start = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_run = 1'b1;
        if (sts.mul_done) state_next = S_INC;
      end
      S_INC: begin
        cmd.inc    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_CSTART;
      end
      S_CSTART: begin
        cmd.cur_start = 1'b1;
        state_next    = S_CMUL;
      end
      S_CMUL: begin
        state_next = S_CUR;
      end
      S_CUR: begin
        cmd.cur    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!m_valid || m_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out)  m_valid <= 1'b1;
      else if (m_ready)  m_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/core/current_sense_averager_with_stats.sv @@
// Top level: current-sense averager with ring moving sum and Welford statistics.
//
// Input stream (s_axis): one beat per sample tick. tuser[0] = action (1 clears the
// statistics, bus_ack and sample ignored), tuser[1] = bus_ack, tdata = shunt sample.
// Output stream (m_axis): exactly one result beat per input beat, in order.
// Config port: cfg_we writes cfg_wdata to register cfg_index (0 zero_offset,
// 1 sign_negative, 2 fault_limit); write only while the block is idle.
// Steps: an acknowledged sample goes through update, mean divide (start, then one
// quotient bit per cycle over 34 bits for 16 fraction bits, then done), multiply,
// M2, current (the divide by 3*depth is a reciprocal multiply) and output load.
// A failure or clear tick skips the mean, multiply and M2 steps. One beat is in
// flight at a time; s_axis_tready is high only while the controller idles, so a new
// beat is not taken until the last one has been loaded into the output register.
// The result sits in an output register, so a new beat is taken while it waits;
// if the receiver stalls, the next result waits in its last step until taken.
// Reset (rst, synchronous) clears counters, ring valid bits, statistics and
// config (fault_limit back to 20); the ring memory itself is not swept.
module current_sense_averager_with_stats import csa_pkg::*; #(
  parameter int WINDOW_DEPTH   = CSA_WINDOW_DEPTH,
  parameter int MEAN_FRAC_BITS = CSA_MEAN_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [15:0] shunt_sample
  input  logic [IN_USER_W-1:0]  s_axis_tuser,  // [0] action, [1] bus_ack
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] sensor_lost, [1] bus_glitch, [33:2] fail_total, [49:34] last_sample,
  // [68:50] window_sum, [88:69] current_ma, [89] window_primed,
  // [121:90] stat_count, [153:122] stat_mean, [216:154] stat_m2,
  // [232:217] stat_min, [248:233] stat_max, rest zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  csa_cmd_t cmd;
  csa_sts_t sts;

  // controller: handshakes and step sequencing
  csa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // datapath: config and model state, the mean divider and the result register
  csa_dp #(
    .WINDOW_DEPTH   (WINDOW_DEPTH),
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_action (s_axis_tuser[0]),
    .in_ack    (s_axis_tuser[1]),
    .in_sample (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (m_axis_tdata)
  );

endmodule

@@ rtl/core/csa_chk.sv @@
// Port-level checker for the averager, bound to the top level.
module csa_chk import csa_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat right after reset");

  // one beat in flight: no back-to-back accept
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while busy");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // a latched fault always comes with a nonzero failure run
  a_lost_run: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[1])
    else $error("sensor_lost without failure run");

  // empty statistics read as zero
  a_empty_stats: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[121:90] == 32'd0) |->
      (m_axis_tdata[153:122] == 32'd0 && m_axis_tdata[216:154] == 63'd0))
    else $error("stats nonzero with zero count");

endmodule

bind current_sense_averager_with_stats csa_chk u_csa_chk (.*);

@@ tb/sv/csa_scoreboard.sv @@
// Scoreboard for the current-sense averager: predicts each result beat and checks it.
module csa_scoreboard import csa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [IN_USER_W-1:0]  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    awaiting,
  output int                    beats_checked
);

  localparam longint unsigned M2_SAT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int NFIELD = 12;
  // output field layout, lowest bit up
  localparam int FLD_LO [NFIELD] = '{0, 1, 2, 34, 50, 69, 89, 90, 122, 154, 217, 233};
  localparam int FLD_W  [NFIELD] = '{1, 1, 32, 16, 19, 20, 1, 32, 32, 63, 16, 16};
  string fld_name [NFIELD] = '{"sensor_lost", "bus_glitch", "fail_total", "last_sample",
                               "window_sum", "current_ma", "window_primed", "stat_count",
                               "stat_mean", "stat_m2", "stat_min", "stat_max"};

  // register copies
  int              offset_reg;
  bit              negate_reg;
  int unsigned     limit_reg;

  // block state copies
  int unsigned     run_len, fail_tot;
  bit              lost;
  int              held;
  int              ring_mem [CSA_WINDOW_DEPTH];
  int              ring_sum;
  int              ring_ptr;
  bit              primed;
  int unsigned     n_samples;
  longint          mean_q;
  longint unsigned m2_acc;
  int              lo_mark, hi_mark;

  logic [OUT_DATA_W-1:0] result_q [$];

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void welford_push(int x);
    longint xf, d, m, e;
    logic [127:0] prod;
    longint unsigned inc;
    xf = longint'(x) * (64'sd1 <<< CSA_MEAN_FRAC_BITS);
    if (n_samples == 0) begin
      lo_mark = x;
      hi_mark = x;
    end else begin
      if (x < lo_mark) lo_mark = x;
      if (x > hi_mark) hi_mark = x;
    end
    if (n_samples != COUNT_MAX) n_samples++;
    d = xf - mean_q;
    m = mean_q + round_div(d, n_samples);
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    mean_q = m;
    e = xf - m;
    prod = 128'((d < 0) ? -d : d) * 128'((e < 0) ? -e : e);
    prod = (prod + (128'd1 << (2 * CSA_MEAN_FRAC_BITS - 1))) >> (2 * CSA_MEAN_FRAC_BITS);
    inc = (prod > 128'(M2_SAT)) ? M2_SAT : prod[63:0];
    if (((d < 0) == (e < 0)) || d == 0 || e == 0)
      m2_acc = (m2_acc > M2_SAT - inc) ? M2_SAT : m2_acc + inc;
    else
      m2_acc = (inc > m2_acc) ? 64'd0 : m2_acc - inc;
  endfunction

  // applies one input beat and returns the packed result beat it should produce
  function automatic logic [OUT_DATA_W-1:0] tick_result(bit clr, bit ack, int x);
    logic [OUT_DATA_W-1:0] r;
    longint cur;
    if (clr) begin
      n_samples = 0; mean_q = 0; m2_acc = 0; lo_mark = 0; hi_mark = 0;
    end else if (!ack) begin
      fail_tot++;
      if (run_len < RUN_MAX) run_len++;
      if (run_len >= limit_reg) lost = 1'b1;
    end else begin
      run_len = 0;
      lost = 1'b0;
      held = x;
      ring_sum = ring_sum - ring_mem[ring_ptr] + x;
      ring_mem[ring_ptr] = x;
      ring_ptr = (ring_ptr + 1) % CSA_WINDOW_DEPTH;
      if (ring_ptr == 0) primed = 1'b1;
      welford_push(x);
    end
    cur = round_div((longint'(ring_sum) - CSA_WINDOW_DEPTH * longint'(offset_reg)) * MA_NUM,
                    MA_DEN * CSA_WINDOW_DEPTH);
    if (negate_reg) cur = -cur;
    if (cur > 524287) cur = 524287;
    if (cur < -524288) cur = -524288;
    r = '0;
    r[0]       = lost;
    r[1]       = (run_len != 0);
    r[33:2]    = fail_tot;
    r[49:34]   = held[15:0];
    r[68:50]   = ring_sum[18:0];
    r[88:69]   = cur[19:0];
    r[89]      = primed;
    r[121:90]  = n_samples;
    r[153:122] = mean_q[31:0];
    r[216:154] = m2_acc[62:0];
    r[232:217] = lo_mark[15:0];
    r[248:233] = hi_mark[15:0];
    return r;
  endfunction

  assign awaiting = result_q.size();

  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] want;
    logic [OUT_DATA_W-1:0] mask;
    bit bad;
    if (rst) begin
      offset_reg = 0; negate_reg = 0; limit_reg = FAULT_LIMIT_RST;
      run_len = 0; fail_tot = 0; lost = 0; held = 0;
      foreach (ring_mem[i]) ring_mem[i] = 0;
      ring_sum = 0; ring_ptr = 0; primed = 0;
      n_samples = 0; mean_q = 0; m2_acc = 0; lo_mark = 0; hi_mark = 0;
      result_q.delete();
      mismatches <= 0;
      beats_checked <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ZERO_OFFSET: offset_reg = int'($signed(cfg_wdata));
          CFG_SIGN_NEG:    negate_reg = cfg_wdata[0];
          CFG_FAULT_LIMIT: limit_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        result_q.push_back(tick_result(s_tuser[0], s_tuser[1], int'($signed(s_tdata))));
      if (m_tvalid && m_tready) begin
        beats_checked <= beats_checked + 1;
        if (result_q.size() == 0) begin
          if (mismatches < 10) $display("[%0t] result beat with nothing pending", $realtime);
          mismatches <= mismatches + 1;
        end else begin
          want = result_q.pop_front();
          bad = 0;
          for (int f = 0; f < NFIELD; f++) begin
            mask = (({{(OUT_DATA_W-1){1'b0}}, 1'b1}) << FLD_W[f]) - 1;
            if (((want >> FLD_LO[f]) & mask) != ((m_tdata >> FLD_LO[f]) & mask)) begin
              if (!bad && mismatches < 10)
                $display("[%0t] beat %0d %s: expected %0h, got %0h", $realtime,
                         beats_checked, fld_name[f], (want >> FLD_LO[f]) & mask,
                         (m_tdata >> FLD_LO[f]) & mask);
              bad = 1;
            end
          end
          if (bad) mismatches <= mismatches + 1;
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_current_sense_averager_with_stats.sv @@
// Testbench top: drives sample ticks and register writes, gives the verdict.
module tb_current_sense_averager_with_stats;
  import csa_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [15:0] shunt_sample
  logic [IN_USER_W-1:0]  s_axis_tuser;   // [0] action, [1] bus_ack
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // sensor_lost .. stat_max, see scoreboard
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches, awaiting, beats_checked;
  int items_sent, burst_left, idle_cycles, rdy_mode, rdy_cnt;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 120;  // well past one tick's latency

  current_sense_averager_with_stats i_dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  csa_scoreboard i_scoreboard (
    .clk, .rst,
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
    .cfg_we, .cfg_index, .cfg_wdata,
    .mismatches, .awaiting, .beats_checked
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver backpressure: the mode is drawn at random from the four below.
  // 0 always ready, 1 coin flip, 2 mostly stalled, 3 periodic.
  always @(posedge clk) begin
    if (rst) begin
      rdy_cnt <= 0;
      rdy_mode <= 0;
      m_axis_tready <= 1'b0;
    end else begin
      rdy_cnt <= rdy_cnt + 1;
      if (rdy_cnt % 64 == 63) rdy_mode <= $urandom_range(0, 3);
      case (rdy_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        2: m_axis_tready <= ($urandom_range(0, 9) == 0);
        default: m_axis_tready <= rdy_cnt[2];
      endcase
    end
  end

  // Watchdog: cycles without any beat accepted on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results still pending", awaiting);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One sample tick; the sender runs in bursts with random gaps in between.
  task automatic send_tick(bit clr, bit ack, logic [15:0] shunt);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {ack, clr};
    s_axis_tdata  <= shunt;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_shunt();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($signed($urandom_range(0, 128)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random mix: mostly good samples, failure runs of varying length, rare clears
  task automatic random_ticks(int count);
    int r, run;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_tick(1'b1, $urandom_range(0, 1), 16'($urandom));
      end else if (r < 14) begin
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
        repeat (run) send_tick(1'b0, 1'b0, 16'($urandom));
      end else begin
        send_tick(1'b0, 1'b1, pick_shunt());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_ZERO_OFFSET;
    cfg_wdata = '0;
    items_sent = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full positive window, extremes, clear, failures, recovery
    repeat (8) send_tick(1'b0, 1'b1, 16'h7FFF);
    send_tick(1'b0, 1'b1, 16'h8000);
    send_tick(1'b0, 1'b1, 16'h0000);
    send_tick(1'b0, 1'b1, 16'hFFFF);
    send_tick(1'b0, 1'b1, 16'h0001);
    send_tick(1'b1, 1'b1, 16'h1234);       // clear: ack and sample ignored
    send_tick(1'b1, 1'b0, 16'hFFFF);       // clear with nothing accumulated
    send_tick(1'b0, 1'b1, 16'h8000);       // first sample after clear sets min and max
    repeat (4) send_tick(1'b0, 1'b0, 16'h7FFF);  // failures ignore the sample
    send_tick(1'b0, 1'b1, 16'h7FFF);
    drain();

    // Short fault limit: a single missed ack latches the fault, negated current
    write_reg(CFG_FAULT_LIMIT, 16'd1);
    write_reg(CFG_SIGN_NEG, 16'd1);
    write_reg(CFG_ZERO_OFFSET, 16'h8000);
    send_tick(1'b0, 1'b0, 16'h0000);
    send_tick(1'b0, 1'b1, 16'h7FFF);
    random_ticks(155);
    drain();

    // Largest limit and offset, positive sign
    write_reg(CFG_FAULT_LIMIT, 16'hFFFF);
    write_reg(CFG_SIGN_NEG, 16'd0);
    write_reg(CFG_ZERO_OFFSET, 16'h7FFF);
    random_ticks(155);
    drain();

    // Limit of zero: any failure counts as lost
    write_reg(CFG_FAULT_LIMIT, 16'd0);
    write_reg(CFG_ZERO_OFFSET, 16'd0);
    random_ticks(155);
    drain();

    // Back to the reset limit, random offset, negated sign
    write_reg(CFG_FAULT_LIMIT, 16'd20);
    write_reg(CFG_SIGN_NEG, 16'd1);
    write_reg(CFG_ZERO_OFFSET, 16'($urandom));
    random_ticks(155);
    drain();

    write_reg(CFG_FAULT_LIMIT, 16'($urandom_range(2, 12)));
    write_reg(CFG_SIGN_NEG, 16'($urandom_range(0, 1)));
    write_reg(CFG_ZERO_OFFSET, 16'($signed($urandom_range(0, 400)) - 200));
    random_ticks(155);
    drain();

    $display("Covered %0d sample ticks (good, failed, clears) over five register settings;",
             items_sent);
    $display("%0d result beats compared, %0d mismatching.", beats_checked, mismatches);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/csa_pkg.sv
rtl/core/csa_div.sv
rtl/core/csa_dp.sv
rtl/core/csa_ctrl.sv
rtl/core/current_sense_averager_with_stats.sv
rtl/core/csa_chk.sv
tb/sv/csa_scoreboard.sv
tb/sv/tb_current_sense_averager_with_stats.sv
